FILE: rtl/keyed_table_with_compaction_assert.svh
// Assertion macros for the keyed table block.
// Included by ktc_ctrl, which checks its own control logic; needs nothing else.
`ifndef KEYED_TABLE_WITH_COMPACTION_ASSERT_SVH
`define KEYED_TABLE_WITH_COMPACTION_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge
`define KTC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the following edge
`define KTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ktc_pkg.sv
// Shared types and constants for the keyed table block.
// Used by the channel interfaces, the sequencer and the top level; depends on nothing.
`default_nettype none

package ktc_pkg;

   // Fixed field widths of the channels
   localparam int REQ_W    = 2;
   localparam int KEY_W    = 15;
   localparam int TAG_W    = 16;
   localparam int POS_W    = 4;
   localparam int CNT_O_W  = 5;

   // Defaults for the top-level parameters
   localparam int SLOTS_DEF     = 16;
   localparam int NAME_BITS_DEF = 16;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SET       = 2'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE    = 2'd2;
   localparam logic [REQ_W-1:0] REQ_FIND      = 2'd3;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] name_tag;
   } ktc_req_type;

   typedef struct packed {
      logic               hit;
      logic [POS_W-1:0]   position;
      logic [TAG_W-1:0]   found_name;
      logic [POS_W-1:0]   selected_index;
      logic [CNT_O_W-1:0] entry_count;
      logic               full_error;
   } ktc_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/ktc_chan_if.sv
// Valid/ready channel interfaces for requests and responses of the keyed table.
// Depends on ktc_pkg for the field widths.
`default_nettype none

interface ktc_req_if;
   import ktc_pkg::*;

   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic [KEY_W-1:0] key;
   logic [TAG_W-1:0] name_tag;

   modport source (output valid, output req_type, output key, output name_tag, input ready);
   modport sink   (input valid, input req_type, input key, input name_tag, output ready);
endinterface

interface ktc_rsp_if;
   import ktc_pkg::*;

   logic               valid;
   logic               ready;
   logic               hit;
   logic [POS_W-1:0]   position;
   logic [TAG_W-1:0]   found_name;
   logic [POS_W-1:0]   selected_index;
   logic [CNT_O_W-1:0] entry_count;
   logic               full_error;

   modport source (output valid, output hit, output position, output found_name,
                   output selected_index, output entry_count, output full_error,
                   input ready);
   modport sink   (input valid, input hit, input position, input found_name,
                   input selected_index, input entry_count, input full_error,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/ktc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
`default_nettype none

module ktc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ktc_ctrl.sv
// Sequencer of the keyed table: walks the slot memory to look up a key,
// then updates, appends, compacts or clears entries. Depends on ktc_pkg and the assertion macros.
`default_nettype none
`include "keyed_table_with_compaction_assert.svh"

module ktc_ctrl #(
   parameter int SLOTS     = ktc_pkg::SLOTS_DEF,
   parameter int NAME_BITS = ktc_pkg::NAME_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request side
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire ktc_pkg::ktc_req_type                in_cmd,
   // result side
   output logic                                     res_valid,
   input  wire logic                                res_ready,
   output ktc_pkg::ktc_rsp_type                     res,
   // slot memory
   output logic                                     wr_en,
   output logic [$clog2(SLOTS)-1:0]                 wr_addr,
   output logic [ktc_pkg::KEY_W+NAME_BITS-1:0]      wr_data,
   output logic                                     rd_en,
   output logic [$clog2(SLOTS)-1:0]                 rd_addr,
   input  wire logic [ktc_pkg::KEY_W+NAME_BITS-1:0] rd_data
);
   import ktc_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int ENT_W = KEY_W + NAME_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_APPLY = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   ktc_req_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     sel_ff, sel_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pidx_ff, pidx_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [NAME_BITS-1:0] fname_ff, fname_in;
   logic                 full_ff, full_in;

   logic [KEY_W-1:0]       rd_key;
   logic                   key_zero;
   logic                   more;
   logic                   match;
   logic [NAME_BITS+TAG_W-1:0] name_in_wide;
   logic [NAME_BITS-1:0]   name_new;
   logic [NAME_BITS+TAG_W-1:0] fname_wide;
   logic [IDX_W+POS_W-1:0] pos_wide;
   logic [IDX_W+POS_W-1:0] sel_wide;
   logic [CNT_W+CNT_O_W-1:0] cnt_wide;

   assign rd_key       = rd_data[ENT_W-1 -: KEY_W];
   assign key_zero     = (cmd_ff.key == '0);
   assign more         = (issue_ff < cnt_ff);
   assign match        = pend_ff && (rd_key == cmd_ff.key);
   assign name_in_wide = {{NAME_BITS{1'b0}}, cmd_ff.name_tag};
   assign name_new     = name_in_wide[NAME_BITS-1:0];

   // Sequencer: lookup walk, update, compaction
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      issue_in = issue_ff;
      pend_in  = 1'b0;
      pidx_in  = pidx_ff;
      hit_in   = hit_ff;
      pos_in   = pos_ff;
      fname_in = fname_ff;
      full_in  = full_ff;
      in_ready = 1'b0;
      res_valid = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_data  = {cmd_ff.key, name_new};
      rd_en    = 1'b0;
      rd_addr  = issue_ff[IDX_W-1:0];
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd_in   = in_cmd;
               issue_in = '0;
               full_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one read per cycle, compare the one that came back
            if (match) begin
               hit_in   = 1'b1;
               pos_in   = pidx_ff;
               fname_in = rd_data[NAME_BITS-1:0];
               state_in = S_APPLY;
            end else if (key_zero || !more) begin
               hit_in   = 1'b0;
               pos_in   = '0;
               fname_in = '0;
               state_in = S_APPLY;
            end else begin
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               pidx_in  = issue_ff[IDX_W-1:0];
               issue_in = issue_ff + CNT_W'(1);
            end
         end
         S_APPLY: begin
            state_in = S_DONE;
            case (cmd_ff.req_type)
               REQ_CLEAR_ALL: begin
                  cnt_in = '0;
               end
               REQ_SET: begin
                  if (!key_zero) begin
                     if (hit_ff) begin
                        wr_en = 1'b1;
                     end else if (cnt_ff < CNT_W'(SLOTS)) begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_ff[IDX_W-1:0];
                        cnt_in  = cnt_ff + CNT_W'(1);
                     end else begin
                        full_in = 1'b1;
                     end
                  end
               end
               REQ_REMOVE: begin
                  if (!key_zero) begin
                     sel_in = '0;
                     if (hit_ff) begin
                        issue_in = CNT_W'(pos_ff) + CNT_W'(1);
                        state_in = S_SHIFT;
                     end
                  end
               end
               REQ_FIND: begin
                  if (hit_ff) begin
                     sel_in = pos_ff;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SHIFT: begin
            // move each later entry down one slot, then drop the count
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff - IDX_W'(1);
               wr_data = rd_data;
            end
            if (more) begin
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               pidx_in  = issue_ff[IDX_W-1:0];
               issue_in = issue_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result fields, masked to the channel widths
   assign fname_wide = {{TAG_W{1'b0}}, fname_ff};
   assign pos_wide   = {{POS_W{1'b0}}, pos_ff};
   assign sel_wide   = {{POS_W{1'b0}}, sel_ff};
   assign cnt_wide   = {{CNT_O_W{1'b0}}, cnt_ff};

   always_comb begin
      res.hit            = hit_ff;
      res.position       = pos_wide[POS_W-1:0];
      res.found_name     = fname_wide[TAG_W-1:0];
      res.selected_index = sel_wide[POS_W-1:0];
      res.entry_count    = cnt_wide[CNT_O_W-1:0];
      res.full_error     = full_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         pend_ff  <= pend_in;
      end
   end

   // Working registers of the current transfer
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      issue_ff <= issue_in;
      pidx_ff  <= pidx_in;
      hit_ff   <= hit_in;
      pos_ff   <= pos_in;
      fname_ff <= fname_in;
      full_ff  <= full_in;
   end

   `KTC_ASSERT_NOW(a_no_rw_collide, clock, reset, wr_en && rd_en, wr_addr != rd_addr, "slot read and written in the same cycle")
   `KTC_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(SLOTS), "entry count above table size")
   `KTC_ASSERT_NEXT(a_accept_scan, clock, reset, in_valid && in_ready, state_ff == S_SCAN, "accepted request did not start a lookup")
   `KTC_ASSERT_NOW(a_shift_remove, clock, reset, state_ff == S_SHIFT, cmd_ff.req_type == REQ_REMOVE && hit_ff, "compaction without a removed entry")
   `KTC_ASSERT_NOW(a_pend_read, clock, reset, pend_ff, $past(rd_en), "compare without a read issued")

endmodule

`default_nettype wire

FILE: rtl/keyed_table_with_compaction.sv
// Top level of the compacting keyed table: slot memory, sequencer and response register.
// Depends on ktc_pkg, ktc_chan_if, ktc_ram and ktc_ctrl.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+----------------------------------------------
//   req_ch  | in  | valid/ready         | req_type, key, name_tag
//   rsp_ch  | out | valid/ready         | hit, position, found_name, selected_index,
//           |     |                     | entry_count, full_error
//
// One request at a time. The lookup walks the slot memory one read per cycle, stopping at the
// match. A remove with a match then moves each later entry down one slot, as compaction
// reads and writes one slot a cycle.
// Synchronous reset empties the table through the fill count; no memory pass is needed.
// The response register frees the sequencer, so the next request is taken while the
// previous response still waits; only a second finished response stalls the sequencer.
`default_nettype none

module keyed_table_with_compaction #(
   parameter int SLOTS     = ktc_pkg::SLOTS_DEF,
   parameter int NAME_BITS = ktc_pkg::NAME_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ktc_req_if.sink   req_ch,
   ktc_rsp_if.source rsp_ch
);
   import ktc_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int ENT_W = KEY_W + NAME_BITS;

   ktc_req_type       req_cmd;
   ktc_rsp_type       res;
   logic              res_valid;
   logic              res_ready;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENT_W-1:0]  rd_data;
   logic              rsp_vld_ff, rsp_vld_in;
   ktc_rsp_type       rsp_dat_ff, rsp_dat_in;

   assign req_cmd.req_type = req_ch.req_type;
   assign req_cmd.key      = req_ch.key;
   assign req_cmd.name_tag = req_ch.name_tag;

   ktc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ktc_ctrl #(
      .SLOTS     (SLOTS),
      .NAME_BITS (NAME_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_cmd    (req_cmd),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Response register: load when empty or drained this cycle, drop after transfer
   assign res_ready = !rsp_vld_ff || rsp_ch.ready;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_dat_in = rsp_dat_ff;
      if (res_valid && res_ready) begin
         rsp_vld_in = 1'b1;
         rsp_dat_in = res;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dat_ff <= rsp_dat_in;
   end

   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.hit            = rsp_dat_ff.hit;
   assign rsp_ch.position       = rsp_dat_ff.position;
   assign rsp_ch.found_name     = rsp_dat_ff.found_name;
   assign rsp_ch.selected_index = rsp_dat_ff.selected_index;
   assign rsp_ch.entry_count    = rsp_dat_ff.entry_count;
   assign rsp_ch.full_error     = rsp_dat_ff.full_error;

endmodule

`default_nettype wire
